>>> hdl/lzssinv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the inverted-byte LZSS decompressor.
// No dependencies; imported by every module of the block.
package lzssinv_pkg;

    localparam int RING_DEPTH_DEF  = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int LEN_W           = 24;
    localparam int OFS_W           = 12;
    localparam int CPY_W           = 5;
    localparam int MIN_COPY        = 3;
    localparam int MAX_COPY        = 18;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_error;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_LIT  = 2'd0,
        CMD_COPY = 2'd1,
        CMD_END  = 2'd2
    } cmd_kind_t;

    // One decoded token handed from the parser to the copy engine.
    typedef struct packed {
        cmd_kind_t        kind;
        logic             fin;
        logic [7:0]       lit;
        logic [OFS_W-1:0] offset;
        logic [CPY_W-1:0] len;
    } cmd_t;

endpackage

>>> hdl/lzssinv_front.sv
`timescale 1ns / 1ps
// Token parser: un-inverts input bytes, tracks flag bits and pair halves,
// and pushes literal / copy / end-of-stream commands. Depends on lzssinv_pkg.
module lzssinv_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lzssinv_pkg::in_item_t in_data,
    input  logic                  clearing,
    input  logic                  q_full,
    output logic                  q_push,
    output lzssinv_pkg::cmd_t     q_cmd
);
    import lzssinv_pkg::*;

    typedef enum logic [2:0] {
        PH_FLAG  = 3'b001,
        PH_TOKEN = 3'b010,
        PH_HIGH  = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] flags_reg, flags_next;
    logic [3:0] left_reg, left_next;
    logic [7:0] low_reg, low_next;
    logic       accept;
    logic       end_tok;
    logic [7:0] b;

    assign in_stall = clearing || q_full;
    assign accept   = in_valid && !in_stall;
    assign b        = ~in_data.in_byte;

    always_comb
    begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        left_next    = left_reg;
        low_next     = low_reg;
        end_tok      = 1'b0;
        q_push       = 1'b0;
        q_cmd.kind   = CMD_END;
        q_cmd.fin    = in_data.in_final;
        q_cmd.lit    = b;
        q_cmd.offset = {b, low_reg[7:4]};
        q_cmd.len    = CPY_W'(low_reg[3:0]) + CPY_W'(MIN_COPY);
        if (accept)
        begin
            unique case (phase_reg)
                PH_FLAG:
                begin
                    flags_next = b;
                    left_next  = 4'd8;
                    phase_next = PH_TOKEN;
                    q_push     = in_data.in_final;
                end
                PH_TOKEN:
                begin
                    if (flags_reg[7])
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_LIT;
                        end_tok    = 1'b1;
                    end
                    else
                    begin
                        low_next   = b;
                        phase_next = PH_HIGH;
                        q_push     = in_data.in_final;
                    end
                end
                PH_HIGH:
                begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_COPY;
                    end_tok    = 1'b1;
                end
                default:
                begin
                    phase_next = PH_FLAG;
                end
            endcase
            if (end_tok)
            begin
                flags_next = {flags_reg[6:0], 1'b0};
                left_next  = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
                phase_next = (left_next != 4'd0) ? PH_TOKEN : PH_FLAG;
            end
            if (in_data.in_final)
            begin
                phase_next = PH_FLAG;
                flags_next = 8'd0;
                left_next  = 4'd0;
                low_next   = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAG;
            flags_reg <= 8'd0;
            left_reg  <= 4'd0;
            low_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            left_reg  <= left_next;
            low_reg   <= low_next;
        end
    end

endmodule

>>> hdl/lzssinv_queue.sv
`timescale 1ns / 1ps
// Small command FIFO between parser and copy engine.
// Depends on lzssinv_pkg (cmd_t).
module lzssinv_queue #(
    parameter int DEPTH = lzssinv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lzssinv_pkg::cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output lzssinv_pkg::cmd_t head
);
    import lzssinv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != CW'(0));
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/lzssinv_back.sv
`timescale 1ns / 1ps
// Copy engine: history ring, byte counter, copy loop with write forwarding,
// ring clearing sweep and the output register. Depends on lzssinv_pkg.
module lzssinv_back #(
    parameter int RING_DEPTH = lzssinv_pkg::RING_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lzssinv_pkg::LEN_W-1:0] output_length,
    input  logic                         q_valid,
    input  lzssinv_pkg::cmd_t            q_cmd,
    output logic                         q_pop,
    output logic                         clearing,
    output logic                         out_valid,
    input  logic                         out_stall,
    output lzssinv_pkg::out_item_t       out_data
);
    import lzssinv_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] RING_START = AW'(RING_DEPTH - MAX_COPY);
    localparam logic [AW-1:0] RING_LAST  = AW'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_COPY  = 3'b100
    } state_t;

    logic [7:0] ring_mem [RING_DEPTH];
    logic [7:0] rd_q_reg;

    state_t           state_reg, state_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [CPY_W-1:0] rem_reg, rem_next;
    logic             fin_reg, fin_next;
    logic             fwd_hit_reg, fwd_hit_next;
    logic [7:0]       fwd_data_reg, fwd_data_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             can_take;
    logic             done;
    logic [LEN_W-1:0] cnt_inc;
    logic             reached;
    logic [LEN_W:0]   copy_end;
    logic [7:0]       copy_byte;

    assign can_take  = !out_valid_reg || !out_stall;
    assign done      = (count_reg >= output_length);
    assign cnt_inc   = count_reg + LEN_W'(1);
    assign reached   = (cnt_inc >= output_length);
    assign copy_end  = {1'b0, count_reg} + (LEN_W + 1)'(q_cmd.len);
    assign copy_byte = fwd_hit_reg ? fwd_data_reg : rd_q_reg;
    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        clr_next       = clr_reg;
        src_next       = src_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        fin_next       = fin_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = q_cmd.lit;
        mem_re         = 1'b0;
        mem_raddr      = src_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'd0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == RING_LAST)
                begin
                    state_next = ST_IDLE;
                    wp_next    = RING_START;
                    count_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && can_take)
                begin
                    q_pop = 1'b1;
                    if (done)
                    begin
                        if (q_cmd.fin)
                        begin
                            state_next = ST_CLEAR;
                            clr_next   = '0;
                        end
                    end
                    else
                    begin
                        case (q_cmd.kind)
                            CMD_LIT:
                            begin
                                if (q_cmd.fin && !reached)
                                begin
                                    out_valid_next = 1'b1;
                                    out_data_next  = '{out_byte: 8'd0, out_last: 1'b1,
                                                       out_error: 1'b1};
                                end
                                else
                                begin
                                    mem_we         = 1'b1;
                                    wp_next        = wp_reg + AW'(1);
                                    count_next     = cnt_inc;
                                    out_valid_next = 1'b1;
                                    out_data_next  = '{out_byte: q_cmd.lit, out_last: reached,
                                                       out_error: 1'b0};
                                end
                                if (q_cmd.fin)
                                begin
                                    state_next = ST_CLEAR;
                                    clr_next   = '0;
                                end
                            end
                            CMD_COPY:
                            begin
                                if (q_cmd.fin && (copy_end < {1'b0, output_length}))
                                begin
                                    out_valid_next = 1'b1;
                                    out_data_next  = '{out_byte: 8'd0, out_last: 1'b1,
                                                       out_error: 1'b1};
                                    state_next     = ST_CLEAR;
                                    clr_next       = '0;
                                end
                                else
                                begin
                                    mem_re       = 1'b1;
                                    mem_raddr    = AW'(q_cmd.offset);
                                    src_next     = AW'(q_cmd.offset) + AW'(1);
                                    rem_next     = q_cmd.len;
                                    fin_next     = q_cmd.fin;
                                    fwd_hit_next = 1'b0;
                                    state_next   = ST_COPY;
                                end
                            end
                            CMD_END:
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '{out_byte: 8'd0, out_last: 1'b1,
                                                   out_error: 1'b1};
                                state_next     = ST_CLEAR;
                                clr_next       = '0;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_COPY:
            begin
                if (can_take)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = copy_byte;
                    wp_next        = wp_reg + AW'(1);
                    count_next     = cnt_inc;
                    rem_next       = rem_reg - CPY_W'(1);
                    out_valid_next = 1'b1;
                    out_data_next  = '{out_byte: copy_byte, out_last: reached, out_error: 1'b0};
                    if ((rem_reg == CPY_W'(1)) || reached)
                    begin
                        state_next = fin_reg ? ST_CLEAR : ST_IDLE;
                        clr_next   = '0;
                    end
                    else
                    begin
                        // next read may hit the entry written in this same cycle
                        mem_re        = 1'b1;
                        mem_raddr     = src_reg;
                        src_next      = src_reg + AW'(1);
                        fwd_hit_next  = (src_reg == wp_reg);
                        fwd_data_next = copy_byte;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q_reg <= ring_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        rem_reg      <= rem_next;
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= RING_START;
            clr_reg       <= '0;
            count_reg     <= '0;
            fin_reg       <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            fin_reg       <= fin_next;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/lzss_inverted_decompressor_top.sv
`timescale 1ns / 1ps
// LZSS decompressor, 4 KiB window, bit-inverted compressed input.
// Input channel: in_valid / in_stall with in_data (one compressed byte plus an
//   end-of-stream mark); a transaction completes when in_valid && !in_stall.
// Output channel: out_valid / out_stall with out_data (byte, last, error).
// cfg_write_en / cfg_write_data load the 24-bit expected output length; write
//   it only while the block is idle.
// A parser accepts bytes and decodes tokens into a 4-entry command queue; a
//   copy engine drains the queue through the history ring into an output
//   register, so input keeps flowing while a result waits on out_stall.
// A literal passes through the command queue and then the output register before
//   it shows on out_valid. Throughput: at most one output byte per cycle while
//   out_stall is low; a pair token's first copied byte waits for the registered
//   ring read that the engine starts when it takes the token.
// Reset and every end of stream start a ring clearing sweep that zeroes every
//   entry, one entry per cycle; in_stall is high for that sweep. After end of
//   stream the engine waits for the sweep before the next stream's commands.
// When the receiver stalls, the output register holds; the engine stops, the
//   queue fills and in_stall rises.
// Depends on lzssinv_pkg, lzssinv_front, lzssinv_queue, lzssinv_back.
module lzss_inverted_decompressor_top #(
    parameter int RING_DEPTH  = lzssinv_pkg::RING_DEPTH_DEF,
    parameter int QUEUE_DEPTH = lzssinv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  lzssinv_pkg::in_item_t         in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output lzssinv_pkg::out_item_t        out_data,
    input  logic                          cfg_write_en,
    input  logic [lzssinv_pkg::LEN_W-1:0] cfg_write_data
);
    import lzssinv_pkg::*;

    logic [LEN_W-1:0] out_len_reg;
    logic             clearing;
    logic             q_full;
    logic             q_push;
    cmd_t             push_cmd;
    logic             q_pop;
    logic             q_valid;
    cmd_t             head_cmd;

    // expected length per stream; survives end of stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_len_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            out_len_reg <= cfg_write_data;
        end
    end

    lzssinv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    lzssinv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_cmd)
    );

    lzssinv_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .output_length (out_len_reg),
        .q_valid       (q_valid),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule

>>> hdl/lzssinv_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the decompressor top level, plus the bind that
// attaches them. Depends on lzssinv_pkg and lzss_inverted_decompressor_top.
module lzssinv_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input lzssinv_pkg::out_item_t out_data
);
    import lzssinv_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed under stall");

    // error result is a zero byte that closes the stream
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_error |-> out_data.out_last && (out_data.out_byte == 8'd0))
        else $error("malformed error result");

    // nothing follows the last byte right away: engine is done or clearing
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_last && !out_stall |=> !out_valid)
        else $error("result right after end of stream");

    // ring sweep after reset blocks input
    a_rst_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input open during ring sweep");

endmodule

bind lzss_inverted_decompressor_top lzssinv_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> tb/sv/lzssinv_stream_checker.sv
`timescale 1ns / 1ps
// Stream checker for the inverted-byte LZSS decompressor: decodes each accepted
// input transaction into the output bytes it must cause and compares them in order.
// Depends on lzssinv_pkg.
module lzssinv_stream_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  lzssinv_pkg::in_item_t         in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  lzssinv_pkg::out_item_t        out_data,
    input  logic                          cfg_write_en,
    input  logic [lzssinv_pkg::LEN_W-1:0] cfg_write_data,
    output int                            fail_count,
    output int                            waiting,
    output int                            compared
);
    import lzssinv_pkg::*;

    localparam int          RING       = 4096;
    localparam logic [11:0] RING_START = 12'd4078;

    typedef enum logic [1:0] {
        PARSE_FLAG,
        PARSE_TOKEN,
        PARSE_HIGH,
        PARSE_DONE
    } parse_t;

    logic [7:0]       history [RING];
    logic [11:0]      wr_pos;
    logic [7:0]       flags;
    logic [3:0]       tokens_left;
    parse_t           phase;
    logic [7:0]       pair_lo;
    logic [LEN_W-1:0] emitted;
    logic [LEN_W-1:0] target_len;
    logic             hit_len;
    out_item_t        step_bytes[$];
    out_item_t        expected_bytes[$];
    out_item_t        want;
    int               failures = 0;
    int               matched = 0;

    function automatic void restart_stream();
        for (int i = 0; i < RING; i++)
            history[i] = 8'h00;
        wr_pos      = RING_START;
        flags       = '0;
        tokens_left = '0;
        phase       = PARSE_FLAG;
        pair_lo     = '0;
        emitted     = '0;
    endfunction

    function automatic void add_result(input out_item_t r);
        step_bytes = {step_bytes, r};
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        history[wr_pos] = b;
        wr_pos  = wr_pos + 1'b1;
        emitted = emitted + 1'b1;
        hit_len = (emitted >= target_len);
        add_result(out_item_t'{b, hit_len, 1'b0});
    endfunction

    function automatic void next_token();
        flags = flags << 1;
        if (tokens_left != 0)
            tokens_left = tokens_left - 1'b1;
        phase = (tokens_left != 0) ? PARSE_TOKEN : PARSE_FLAG;
    endfunction

    function automatic void decode_byte(input in_item_t item);
        logic [7:0]  b;
        logic [11:0] src;
        int          run;
        b       = ~item.in_byte;
        hit_len = 1'b0;
        step_bytes.delete();
        // length already met (or zero): byte is swallowed until end of stream
        if (phase == PARSE_DONE || emitted >= target_len) begin
            phase = PARSE_DONE;
            if (item.in_final)
                restart_stream();
            return;
        end
        case (phase)
            PARSE_FLAG:
            begin
                flags       = b;
                tokens_left = 4'd8;
                phase       = PARSE_TOKEN;
            end
            PARSE_TOKEN:
            begin
                if (flags[7])
                begin
                    put_byte(b);
                    next_token();
                end
                else
                begin
                    pair_lo = b;
                    phase   = PARSE_HIGH;
                end
            end
            default:
            begin
                // byte-at-a-time copy, so overlapping sources see fresh writes
                src = {b, pair_lo[7:4]};
                run = int'(pair_lo[3:0]) + MIN_COPY;
                for (int i = 0; i < run && !hit_len; i++)
                begin
                    put_byte(history[src]);
                    src = src + 1'b1;
                end
                next_token();
            end
        endcase
        if (hit_len)
            phase = PARSE_DONE;
        if (item.in_final) begin
            restart_stream();
            // short stream: data of the final byte replaced by one error result
            if (!hit_len) begin
                step_bytes.delete();
                add_result(out_item_t'{8'h00, 1'b1, 1'b1});
            end
        end
        expected_bytes = {expected_bytes, step_bytes};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_len = '0;
            restart_stream();
            expected_bytes.delete();
            waiting <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected result transaction: out_byte %0h out_last %0b out_error %0b",
                           out_data.out_byte, out_data.out_last, out_data.out_error);
                    failures++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    matched++;
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %0h, actual %0h",
                               want.out_byte, out_data.out_byte);
                        failures++;
                    end
                    if (out_data.out_last !== want.out_last)
                    begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.out_last, out_data.out_last);
                        failures++;
                    end
                    if (out_data.out_error !== want.out_error)
                    begin
                        $error("out_error mismatch: expected %0b, actual %0b",
                               want.out_error, out_data.out_error);
                        failures++;
                    end
                end
            end
            if (cfg_write_en)
                target_len = cfg_write_data;
            if (in_valid && !in_stall)
                decode_byte(in_data);
            waiting <= expected_bytes.size();
        end
        fail_count <= failures;
        compared   <= matched;
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the decompressor testbench: clock, reset, stimulus, receiver stalls and
// verdict. Depends on lzssinv_pkg, lzss_inverted_decompressor_top, lzssinv_stream_checker.
module testbench;

    import lzssinv_pkg::*;

    // Run stops once about this many compressed bytes have been sent.
    localparam int          ITEM_GOAL   = 310;
    // Cycles without any transaction before the run is declared hung. Longest
    // legal quiet stretch is one ring clearing sweep plus settling.
    localparam int          QUIET_LIMIT = 40000;
    localparam logic [11:0] RING_START  = 12'd4078;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;
    logic             cfg_write_en;
    logic [LEN_W-1:0] cfg_write_data;

    int fail_count;
    int waiting;
    int compared;

    // Plain (not yet inverted) bytes of the stream being built.
    logic [7:0] plain_q[$];

    int   sent = 0;
    int   useful = 0;
    int   streams = 0;
    int   settings = 0;
    int   stall_left = 0;
    int   quiet = 0;
    logic tx_gaps = 1'b0;
    logic rx_gaps = 1'b0;
    logic calm = 1'b0;

    lzss_inverted_decompressor_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    lzssinv_stream_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fail_count     (fail_count),
        .waiting        (waiting),
        .compared       (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: random stall bursts while rx_gaps is on; the calm tail of
    // the run never stalls.
    always @(posedge clk)
    begin
        if (!rst_n || calm || !rx_gaps)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet == QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // One input transaction. Sampling in_stall right after the edge sees the
    // value from before the edge, i.e. the one the handshake used.
    task automatic send_item(input logic [7:0] plain, input logic fin);
        if (tx_gaps && !calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= in_item_t'{~plain, fin};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Sends plain_q bit-inverted, end-of-stream mark on the last byte.
    task automatic send_stream(input logic [LEN_W-1:0] len);
        foreach (plain_q[i])
            send_item(plain_q[i], i == plain_q.size() - 1);
        in_valid <= 1'b0;
        if (len != 0)
            useful += plain_q.size();
        plain_q.delete();
        streams++;
    endtask

    // Waits until the checker holds no expectation (its count is registered,
    // hence the first edge), then lets the pipe settle.
    task automatic wait_drained(input int settle);
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Length register is only touched while the block is idle: results all
    // in, ignored bytes flushed, and the ring clearing sweep over (in_stall low).
    task automatic set_length(input logic [LEN_W-1:0] n);
        wait_drained(40);
        while (in_stall)
            @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= n;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        settings++;
    endtask

    // Appends one plain byte to the stream being built.
    function automatic void add_byte(input logic [7:0] v);
        plain_q = {plain_q, v};
    endfunction

    // Pair token: low byte carries offset[3:0] and length nibble, high byte
    // carries offset[11:4].
    function automatic void add_pair(input logic [11:0] ofs, input logic [3:0] nib);
        add_byte({ofs[3:0], nib});
        add_byte(ofs[11:4]);
    endfunction

    // Mostly well-formed token streams with random content; pairs often point
    // just behind the write position so copies overlap their own output.
    // About one in five streams is plain noise.
    task automatic build_random_stream(input logic [LEN_W-1:0] n);
        int          plan;
        int          target;
        int          cap;
        logic [7:0]  flag;
        logic [11:0] ofs;
        logic [3:0]  nib;
        plan = 0;
        cap  = $urandom_range(8, 60);
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 20))
                add_byte(8'($urandom));
            return;
        end
        // sometimes end the stream short on purpose
        if ($urandom_range(0, 4) == 0)
            target = $urandom_range(0, 40);
        else
            target = int'(n) + $urandom_range(0, 12);
        while (plan < target && plain_q.size() < cap)
        begin
            flag = 8'($urandom);
            add_byte(flag);
            for (int k = 7; k >= 0 && plan < target; k--)
            begin
                if (flag[k])
                begin
                    add_byte(8'($urandom));
                    plan++;
                end
                else
                begin
                    nib = 4'($urandom);
                    if ($urandom_range(0, 1) != 0)
                        ofs = RING_START + 12'(plan) - 12'($urandom_range(1, 24));
                    else
                        ofs = 12'($urandom);
                    add_pair(ofs, nib);
                    plan += int'(nib) + MIN_COPY;
                end
            end
        end
        // trailing bytes land after the length is met (or split a token)
        repeat ($urandom_range(0, 3))
            add_byte(8'($urandom));
        if (plain_q.size() == 0)
            add_byte(8'($urandom));
    endtask

    initial
    begin
        logic [LEN_W-1:0] len;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        repeat (6) @(posedge clk);
        rst_n   <= 1'b1;
        tx_gaps  = 1'b1;
        rx_gaps <= 1'b1;

        // Zero length: both extreme byte values are swallowed, nothing comes out.
        set_length('0);
        plain_q = '{8'h00, 8'hFF};
        send_stream('0);

        // Maximum length, so the stream ends short. Literal, then an 18-byte
        // copy from the byte just written (forwarding), then a 3-byte copy at
        // the top of the ring that wraps to entry 0, a literal, and a final
        // literal whose data is replaced by the error result.
        set_length('1);
        plain_q = '{8'h9F, 8'hFF};
        add_pair(RING_START, 4'hF);
        add_pair(12'hFFF, 4'h0);
        add_byte(8'h00);
        add_byte(8'hA5);
        send_stream('1);

        // Length reached inside a copy from offset 0: copy is cut at 5 bytes,
        // later bytes are ignored up to the end-of-stream mark.
        set_length(24'd5);
        plain_q = '{8'h00};
        add_pair(12'h000, 4'hF);
        add_byte(8'h12);
        add_byte(8'h34);
        add_byte(8'h56);
        send_stream(24'd5);

        // Length reached on the final byte itself: last marked, no error.
        set_length(24'd1);
        plain_q = '{8'hFF, 8'h80};
        send_stream(24'd1);

        // Stream ending on its flag byte, then on the high byte of a pair.
        set_length(24'd3);
        plain_q = '{8'h00};
        send_stream(24'd3);
        set_length(24'h000100);
        plain_q = '{8'h00};
        add_pair(12'h5A5, 4'h7);
        send_stream(24'h000100);

        // Random streams, one length setting each; idling on either side is
        // switched per stream, and the tail of the run runs without idling.
        while (sent < ITEM_GOAL)
        begin
            if (sent > ITEM_GOAL * 5 / 6)
                calm <= 1'b1;
            tx_gaps  = ($urandom_range(0, 2) != 0);
            rx_gaps <= ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = '1;
                2:       len = LEN_W'($urandom_range(1, 4));
                default: len = LEN_W'($urandom_range(1, 180));
            endcase
            set_length(len);
            build_random_stream(len);
            send_stream(len);
        end

        wait_drained(60);
        $display("Covered %0d streams, %0d compressed bytes (%0d under a nonzero length), %0d length settings (0 to max).",
                 streams, sent, useful, settings);
        $display("Compared %0d result transactions, %0d check failures.",
                 compared, fail_count);
        if (fail_count == 0 && waiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> lzss_inverted_decompressor_top.f
hdl/lzssinv_pkg.sv
hdl/lzssinv_front.sv
hdl/lzssinv_queue.sv
hdl/lzssinv_back.sv
hdl/lzss_inverted_decompressor_top.sv
hdl/lzssinv_checker.sv
tb/sv/lzssinv_stream_checker.sv
tb/sv/testbench.sv
